/* hdl/rdz_pkg.sv */
`timescale 1ns / 1ps
package rdz_pkg;

    localparam int REG_BITS = 16;
    localparam int OUT_BITS = 16;

    localparam logic [REG_BITS-1:0] DEAD_RESET = 16'd8000;
    localparam logic [REG_BITS-1:0] FULL_RESET = 16'd30000;

    localparam logic CFG_DEAD_ZONE  = 1'b0;
    localparam logic CFG_FULL_SCALE = 1'b1;

    typedef struct packed {
        logic vld;
        logic neg_x;
        logic neg_y;
        logic dead;
    } t_ctl;

endpackage

/* hdl/rdz_sqrt_cell.sv */
`timescale 1ns / 1ps
module rdz_sqrt_cell
    import rdz_pkg::*;
#(
    parameter int W = 16,
    parameter int K = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  t_ctl           i_ctl,
    input  logic [2*W-1:0] i_rem,
    input  logic [W-1:0]   i_root,
    input  logic [W-1:0]   i_mx,
    input  logic [W-1:0]   i_my,
    output t_ctl           o_ctl,
    output logic [2*W-1:0] o_rem,
    output logic [W-1:0]   o_root,
    output logic [W-1:0]   o_mx,
    output logic [W-1:0]   o_my
);
    localparam int SW = 2 * W + 1;

    logic [SW-1:0]  trial;
    logic           take;
    logic [2*W-1:0] n_rem;
    logic [W-1:0]   n_root;

    always_comb begin
        trial  = ({{(SW-W){1'b0}}, i_root} << (K + 1)) + (SW'(1) << (2 * K));
        take   = {1'b0, i_rem} >= trial;
        n_rem  = take ? (i_rem - trial[2*W-1:0]) : i_rem;
        n_root = take ? (i_root | (W'(1) << K)) : i_root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_root <= n_root;
            o_mx   <= i_mx;
            o_my   <= i_my;
        end
    end
endmodule

/* hdl/rdz_div_cell.sv */
`timescale 1ns / 1ps
module rdz_div_cell
    import rdz_pkg::*;
#(
    parameter int NW = 46,
    parameter int DW = 32,
    parameter int QW = 15,
    parameter int SH = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  t_ctl          i_ctl,
    input  logic [DW-1:0] i_d,
    input  logic [NW-1:0] i_rem_x,
    input  logic [NW-1:0] i_rem_y,
    input  logic [QW-1:0] i_q_x,
    input  logic [QW-1:0] i_q_y,
    output t_ctl          o_ctl,
    output logic [DW-1:0] o_d,
    output logic [NW-1:0] o_rem_x,
    output logic [NW-1:0] o_rem_y,
    output logic [QW-1:0] o_q_x,
    output logic [QW-1:0] o_q_y
);
    localparam int CW = NW + 1;

    logic [CW-1:0] dsh;
    logic          take_x;
    logic          take_y;

    always_comb begin
        dsh    = {{(CW-DW){1'b0}}, i_d} << SH;
        take_x = {1'b0, i_rem_x} >= dsh;
        take_y = {1'b0, i_rem_y} >= dsh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_d     <= i_d;
            o_rem_x <= take_x ? (i_rem_x - dsh[NW-1:0]) : i_rem_x;
            o_rem_y <= take_y ? (i_rem_y - dsh[NW-1:0]) : i_rem_y;
            o_q_x   <= take_x ? (i_q_x | (QW'(1) << SH)) : i_q_x;
            o_q_y   <= take_y ? (i_q_y | (QW'(1) << SH)) : i_q_y;
        end
    end
endmodule

/* hdl/radial_dead_zone_stick_filter.sv */
// Radial dead-zone stick filter. One beat in, one beat out, one beat per cycle sustained
// while no finished beat waits at the output. The datapath holds a chain of
// AXIS_BITS square-root cells giving one length bit each, then OUT_FRAC_BITS + 1
// divider cells giving one quotient bit each for both axes. The whole chain holds
// while a finished beat waits at the output. Configuration writes are taken at once.
`timescale 1ns / 1ps
module radial_dead_zone_stick_filter
    import rdz_pkg::*;
#(
    parameter int AXIS_BITS     = 16,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [AXIS_BITS-1:0] i_axis_x,
    input  logic signed [AXIS_BITS-1:0] i_axis_y,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [OUT_BITS-1:0]  o_scaled_x,
    output logic signed [OUT_BITS-1:0]  o_scaled_y,
    output logic                        o_inside_dead_zone,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [REG_BITS-1:0]         i_cfg_data
);
    localparam int A   = AXIS_BITS;
    localparam int F   = OUT_FRAC_BITS;
    localparam int SQW = 2 * A;
    localparam int PW  = A + REG_BITS;
    localparam int NW  = PW + F;
    localparam int QW  = F + 1;
    localparam int XW  = QW + OUT_BITS;

    logic [REG_BITS-1:0] r_dead;
    logic [REG_BITS-1:0] r_full;
    logic                en;

    assign en          = !o_valid || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead <= DEAD_RESET;
            r_full <= FULL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEAD_ZONE:  r_dead <= i_cfg_data;
                CFG_FULL_SCALE: r_full <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // magnitude
    t_ctl         n_c1, r_c1;
    logic [A-1:0] r_mx1, r_my1;

    always_comb begin
        n_c1       = '0;
        n_c1.vld   = i_valid;
        n_c1.neg_x = i_axis_x[A-1];
        n_c1.neg_y = i_axis_y[A-1];
    end

    // squares
    t_ctl           r_c2, r_c3;
    logic [SQW-1:0] r_sqx, r_sqy, r_sum;
    logic [A-1:0]   r_mx2, r_my2, r_mx3, r_my3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
        end else if (en) begin
            r_c1 <= n_c1;
            r_c2 <= r_c1;
            r_c3 <= r_c2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mx1 <= i_axis_x[A-1] ? (~i_axis_x + A'(1)) : i_axis_x;
            r_my1 <= i_axis_y[A-1] ? (~i_axis_y + A'(1)) : i_axis_y;
            r_sqx <= SQW'(r_mx1) * SQW'(r_mx1);
            r_sqy <= SQW'(r_my1) * SQW'(r_my1);
            r_mx2 <= r_mx1;
            r_my2 <= r_my1;
            r_sum <= r_sqx + r_sqy;
            r_mx3 <= r_mx2;
            r_my3 <= r_my2;
        end
    end

    // square root chain
    t_ctl           s_ctl  [0:A];
    logic [SQW-1:0] s_rem  [0:A];
    logic [A-1:0]   s_root [0:A];
    logic [A-1:0]   s_mx   [0:A];
    logic [A-1:0]   s_my   [0:A];

    assign s_ctl[0]  = r_c3;
    assign s_rem[0]  = r_sum;
    assign s_root[0] = '0;
    assign s_mx[0]   = r_mx3;
    assign s_my[0]   = r_my3;

    for (genvar j = 0; j < A; j++) begin : g_sqrt
        rdz_sqrt_cell #(.W(A), .K(A - 1 - j)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_ctl  (s_ctl[j]),
            .i_rem  (s_rem[j]),
            .i_root (s_root[j]),
            .i_mx   (s_mx[j]),
            .i_my   (s_my[j]),
            .o_ctl  (s_ctl[j+1]),
            .o_rem  (s_rem[j+1]),
            .o_root (s_root[j+1]),
            .o_mx   (s_mx[j+1]),
            .o_my   (s_my[j+1])
        );
    end

    // fraction terms
    logic [A-1:0]        len;
    logic [PW-1:0]       len_w, dead_w;
    logic [PW-1:0]       diff_w;
    logic [REG_BITS-1:0] den_c;
    logic                is_dead;
    logic                unit;
    t_ctl                n_c5, r_c5, r_c6;
    logic [REG_BITS-1:0] r_num, r_den;
    logic [A-1:0]        r_len, r_mx5, r_my5;
    logic [PW-1:0]       r_nx, r_ny, r_d;

    always_comb begin
        len     = s_root[A];
        len_w   = PW'(len);
        dead_w  = PW'(r_dead);
        diff_w  = len_w - dead_w;
        den_c   = r_full - r_dead;
        is_dead = (len == '0) || (len_w < dead_w);
        unit    = (r_full <= r_dead) || (diff_w >= PW'(den_c));
        n_c5      = s_ctl[A];
        n_c5.dead = is_dead;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (en) begin
            r_c5 <= n_c5;
            r_c6 <= r_c5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num <= unit ? REG_BITS'(1) : diff_w[REG_BITS-1:0];
            r_den <= unit ? REG_BITS'(1) : den_c;
            r_len <= len;
            r_mx5 <= s_mx[A];
            r_my5 <= s_my[A];
            r_nx  <= PW'(r_mx5) * PW'(r_num);
            r_ny  <= PW'(r_my5) * PW'(r_num);
            r_d   <= PW'(r_len) * PW'(r_den);
        end
    end

    // divider chain
    t_ctl          d_ctl [0:QW];
    logic [PW-1:0] d_d   [0:QW];
    logic [NW-1:0] d_rx  [0:QW];
    logic [NW-1:0] d_ry  [0:QW];
    logic [QW-1:0] d_qx  [0:QW];
    logic [QW-1:0] d_qy  [0:QW];

    assign d_ctl[0] = r_c6;
    assign d_d[0]   = r_d;
    assign d_rx[0]  = {r_nx, {F{1'b0}}};
    assign d_ry[0]  = {r_ny, {F{1'b0}}};
    assign d_qx[0]  = '0;
    assign d_qy[0]  = '0;

    for (genvar j = 0; j < QW; j++) begin : g_div
        rdz_div_cell #(.NW(NW), .DW(PW), .QW(QW), .SH(F - j)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_ctl  (d_ctl[j]),
            .i_d    (d_d[j]),
            .i_rem_x(d_rx[j]),
            .i_rem_y(d_ry[j]),
            .i_q_x  (d_qx[j]),
            .i_q_y  (d_qy[j]),
            .o_ctl  (d_ctl[j+1]),
            .o_d    (d_d[j+1]),
            .o_rem_x(d_rx[j+1]),
            .o_rem_y(d_ry[j+1]),
            .o_q_x  (d_qx[j+1]),
            .o_q_y  (d_qy[j+1])
        );
    end

    // output
    t_ctl          oc;
    logic [XW-1:0] qx_w, qy_w;

    always_comb begin
        oc   = d_ctl[QW];
        qx_w = XW'(d_qx[QW]);
        qy_w = XW'(d_qy[QW]);
        if (oc.neg_x) begin
            qx_w = ~qx_w + XW'(1);
        end
        if (oc.neg_y) begin
            qy_w = ~qy_w + XW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= oc.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_inside_dead_zone <= oc.dead;
            o_scaled_x <= oc.dead ? '0 : qx_w[OUT_BITS-1:0];
            o_scaled_y <= oc.dead ? '0 : qy_w[OUT_BITS-1:0];
        end
    end
endmodule

/* hdl/rdz_chk.sv */
`timescale 1ns / 1ps
module rdz_chk
    import rdz_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic                       o_cfg_ready,
    input logic signed [OUT_BITS-1:0] o_scaled_x,
    input logic signed [OUT_BITS-1:0] o_scaled_y,
    input logic                       o_inside_dead_zone
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_scaled_x) && $stable(o_scaled_y)
            && $stable(o_inside_dead_zone))
        else $error("output beat changed while stalled");

    a_dead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_inside_dead_zone |-> o_scaled_x == '0 && o_scaled_y == '0)
        else $error("dead-zone beat carries non-zero axes");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid || i_ready |-> o_ready && o_cfg_ready)
        else $error("input held off with free output");
endmodule

bind radial_dead_zone_stick_filter rdz_chk u_rdz_chk (.*);

/* dv/radial_dead_zone_stick_filter_tb.sv */
`timescale 1ns / 1ps
module radial_dead_zone_stick_filter_tb;
    import rdz_pkg::*;

    localparam int LATENCY = 37;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_stick;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               dz;
    } t_filtered;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic signed [15:0]         i_axis_x = '0;
    logic signed [15:0]         i_axis_y = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic signed [OUT_BITS-1:0] o_scaled_x;
    logic signed [OUT_BITS-1:0] o_scaled_y;
    logic                       o_inside_dead_zone;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic                       i_cfg_index = CFG_DEAD_ZONE;
    logic [REG_BITS-1:0]        i_cfg_data = '0;

    radial_dead_zone_stick_filter u_top (.*);

    always #2 i_clk = ~i_clk;

    logic [15:0] dead_r = DEAD_RESET;
    logic [15:0] full_r = FULL_RESET;

    t_stick    stick_q[$];
    t_filtered filtered_q[$];
    int        n_err = 0;
    bit        hold_tx = 1'b0;
    bit        in_acc = 1'b0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        stall_mode = 0;

    function automatic logic [31:0] root32(input logic [31:0] n);
        logic [31:0] r;
        logic [31:0] b;
        logic [31:0] v;
        r = 0;
        b = 32'h4000_0000;
        v = n;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] scale_one(input logic signed [15:0] a,
                                              input logic [63:0] num, input logic [63:0] den,
                                              input logic [63:0] len);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (a < 0) ? 64'(-32'(a)) : 64'(a);
        q = ((mag * num) << 14) / (len * den);
        if (a < 0) q = -q;
        return q[15:0];
    endfunction

    function automatic t_filtered filter_stick(input t_stick s);
        t_filtered r;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [63:0] len;
        logic [63:0] num;
        logic [63:0] den;
        ax = (s.x < 0) ? 32'(-32'(s.x)) : 32'(s.x);
        ay = (s.y < 0) ? 32'(-32'(s.y)) : 32'(s.y);
        len = 64'(root32(ax * ax + ay * ay));
        if (len == 0 || len < 64'(dead_r)) begin
            r.sx = '0;
            r.sy = '0;
            r.dz = 1'b1;
            return r;
        end
        if (full_r <= dead_r) begin
            num = 1;
            den = 1;
        end else begin
            num = len - dead_r;
            den = 64'(full_r - dead_r);
            if (num >= den) begin
                num = 1;
                den = 1;
            end
        end
        r.sx = scale_one(s.x, num, den, len);
        r.sy = scale_one(s.y, num, den, len);
        r.dz = 1'b0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        in_acc <= i_valid && o_ready;
    end

    // driver: bursts and gaps, hold until accepted
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !in_acc) begin
                // hold
            end else if (!hold_tx && stick_q.size() > 0 && gap_left == 0) begin
                t_stick s;
                s = stick_q.pop_front();
                filtered_q.push_back(filter_stick(s));
                i_valid <= 1'b1;
                i_axis_x <= s.x;
                i_axis_y <= s.y;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
            case (stall_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 3) != 0);
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
            if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (filtered_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected beat: x=%0d y=%0d dz=%0b",
                                          o_scaled_x, o_scaled_y, o_inside_dead_zone);
            end else begin
                t_filtered e;
                e = filtered_q.pop_front();
                if (o_scaled_x !== e.sx || o_scaled_y !== e.sy
                        || o_inside_dead_zone !== e.dz) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp x=%0d y=%0d dz=%0b got x=%0d y=%0d dz=%0b",
                                 e.sx, e.sy, e.dz, o_scaled_x, o_scaled_y,
                                 o_inside_dead_zone);
                end
            end
        end
    end

    task automatic drain();
        while (stick_q.size() > 0 || i_valid || filtered_q.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_DEAD_ZONE) dead_r = val;
        else full_r = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add(input int x, input int y);
        t_stick s;
        s.x = 16'(x);
        s.y = 16'(y);
        stick_q.push_back(s);
    endtask

    task automatic add_random(input int n);
        int r;
        int m;
        repeat (n) begin
            r = $urandom_range(0, 9);
            m = (r < 3) ? 1 << $urandom_range(2, 15) : 65536;
            if (r == 9) add(($urandom_range(0, 1) ? -32768 : 32767),
                            $urandom_range(0, 65535) - 32768);
            else add(int'($urandom_range(0, m - 1)) - m / 2,
                     int'($urandom_range(0, m - 1)) - m / 2);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add(0, 0);
        add(-32768, -32768);
        add(32767, 32767);
        add(-32768, 32767);
        add(32767, 0);
        add(0, -32768);
        add(7999, 0);
        add(8000, 0);
        add(0, -8001);
        add(30000, 0);
        add(0, 29999);
        add(-21213, 21213);
        add(5656, 5657);
        add(1, -1);
        add(-1, 0);
        add(19000, -3);
        drain();

        write_reg(CFG_DEAD_ZONE, 16'd0);
        write_reg(CFG_FULL_SCALE, 16'd46341);
        add(0, 0);
        add(1, 0);
        add(-1, 1);
        add(-32768, -32768);
        add_random(60);
        while (stick_q.size() >= 30) @(posedge i_clk);
        hold_tx = 1'b1;
        while (i_valid || filtered_q.size() > 0) @(posedge i_clk);
        hold_tx = 1'b0;
        drain();

        write_reg(CFG_DEAD_ZONE, 16'd20000);
        write_reg(CFG_FULL_SCALE, 16'd100);
        add(20000, 0);
        add_random(60);
        drain();

        write_reg(CFG_DEAD_ZONE, 16'hFFFF);
        write_reg(CFG_FULL_SCALE, 16'hFFFF);
        add(-32768, -32768);
        add_random(30);
        drain();

        write_reg(CFG_DEAD_ZONE, 16'd46341);
        write_reg(CFG_FULL_SCALE, 16'd1);
        add(-32768, -32768);
        add(32767, -32768);
        add_random(20);
        drain();

        write_reg(CFG_DEAD_ZONE, 16'd1);
        write_reg(CFG_FULL_SCALE, 16'd2);
        add_random(40);
        drain();

        repeat (4) begin
            write_reg(CFG_DEAD_ZONE, 16'($urandom_range(0, 20000)));
            write_reg(CFG_FULL_SCALE, 16'($urandom_range(1, 46341)));
            add_random(60);
            drain();
        end

        if (n_err == 0) $display("radial_dead_zone_stick_filter regression: pass");
        else $display("radial_dead_zone_stick_filter regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("radial_dead_zone_stick_filter regression: fail");
        $finish;
    end

endmodule
